/* rtl/pidtm_pkg.sv */
// Package: shared types, register indexes and saturation helpers for the PID unit.
`default_nettype none
package pidtm_pkg;

   localparam int CsrIdxWidth = 3;

   localparam logic [CsrIdxWidth-1:0] CsrMode     = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrGainP    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrGainI    = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrGainD    = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrOutLow   = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CsrOutHigh  = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CsrIntCap   = 3'd6;

   localparam logic signed [31:0] OutLowReset  = -32'sd6553600;
   localparam logic signed [31:0] OutHighReset = 32'sd6553600;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ERR,
      ST_MUL_SEP,
      ST_SEP,
      ST_MUL_EDT,
      ST_INTEG,
      ST_MUL_GI,
      ST_MUL_P,
      ST_MUL_D,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SUM,
      ST_I_MUL_P,
      ST_I_MUL_GI,
      ST_I_MUL_IDT,
      ST_I_MUL_D,
      ST_I_DIV_START,
      ST_I_DIV_WAIT,
      ST_I_SUM,
      ST_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -66'sh0_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   // arithmetic shift = floor, then saturate
   function automatic logic signed [31:0] qfix(input logic signed [63:0] p);
      logic signed [47:0] s;
      s = p[63:16];
      return sat32({{18{s[47]}}, s});
   endfunction

endpackage
`default_nettype wire

/* rtl/pid_controller_two_mode_unit.sv */
// Top level: two-mode Q16.16 PID controller with a shared multiplier and serial divider.
`default_nettype none
// One request word {step_time, measured, target} yields one response word
// {held, drive}. A step_time of zero or less answers with the clamped last
// output and held set, leaving state alone. Otherwise each update makes four
// passes through one pipelined 32x32 multiplier (operands and product
// registered) and one run of the radix-2 divider for the derivative quotient.
// Mode 0 is positional (integral separation, clamped integral, derivative on
// measurement); mode 1 is incremental. req_tready is low while an update runs
// or while a response waits in the output register. CSR writes are meant for
// idle periods only.
module pid_controller_two_mode_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [95:0]  req_tdata,  // target[31:0], measured[63:32], step_time[95:64]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,  // drive[31:0]
   output logic              rsp_tuser,  // held
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);
   typedef logic signed [31:0] s32_type;

   // configuration
   logic    mode_ff;
   s32_type kp_ff, ki_ff, kd_ff, olo_ff, ohi_ff;
   logic [30:0] cap_ff;

   // controller state
   s32_type isum_ff, isum_in, lerr_ff, lerr_in, lout_ff, lout_in, hist_ff, hist_in;

   // item registers
   s32_type t_ff, t_in, m_ff, m_in, dt_ff, dt_in;
   s32_type err_ff, err_in, a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic    integ_ff, integ_in;

   // shared multiplier: operands registered, product registered
   s32_type mx_ff, mx_in, my_ff, my_in;
   logic signed [63:0] prod_ff;
   s32_type mq;

   pidtm_pkg::state_type state_ff, state_in;

   logic    rv_ff, rv_in, held_ff, held_in;
   s32_type drive_ff, drive_in;

   logic    div_start, div_done;
   s32_type div_num, div_q;

   logic    req_fire;
   s32_type lim, clamp_src;
   logic signed [33:0] span;
   s32_type s_tmp;

   assign req_fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == pidtm_pkg::ST_IDLE) && !rv_ff;
   assign mq = pidtm_pkg::qfix(prod_ff);

   pidtm_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(div_num),
      .denom(dt_ff), .done(div_done), .quot(div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0; kp_ff <= '0; ki_ff <= '0; kd_ff <= '0;
         olo_ff <= pidtm_pkg::OutLowReset; ohi_ff <= pidtm_pkg::OutHighReset;
         cap_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            pidtm_pkg::CsrMode:    mode_ff <= csr_wdata[0];
            pidtm_pkg::CsrGainP:   kp_ff <= csr_wdata;
            pidtm_pkg::CsrGainI:   ki_ff <= csr_wdata;
            pidtm_pkg::CsrGainD:   kd_ff <= csr_wdata;
            pidtm_pkg::CsrOutLow:  olo_ff <= csr_wdata;
            pidtm_pkg::CsrOutHigh: ohi_ff <= csr_wdata;
            pidtm_pkg::CsrIntCap:  cap_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // integral limit: cap, or half the span floored (zero if span negative)
   always_comb begin
      span = 34'(ohi_ff) - 34'(olo_ff);
      if (cap_ff != '0) lim = s32_type'({1'b0, cap_ff});
      else if (span[33]) lim = '0;
      else lim = s32_type'(span[32:1]);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pidtm_pkg::ST_IDLE:
            if (req_fire) state_in = pidtm_pkg::ST_ERR;
         pidtm_pkg::ST_ERR:
            if (dt_ff[31] || dt_ff == '0) state_in = pidtm_pkg::ST_OUT;
            else if (mode_ff) state_in = pidtm_pkg::ST_I_MUL_P;
            else state_in = pidtm_pkg::ST_MUL_SEP;
         pidtm_pkg::ST_MUL_SEP:     state_in = pidtm_pkg::ST_SEP;
         pidtm_pkg::ST_SEP:         state_in = pidtm_pkg::ST_MUL_EDT;
         pidtm_pkg::ST_MUL_EDT:     state_in = pidtm_pkg::ST_INTEG;
         pidtm_pkg::ST_INTEG:       state_in = pidtm_pkg::ST_MUL_GI;
         pidtm_pkg::ST_MUL_GI:      state_in = pidtm_pkg::ST_MUL_P;
         pidtm_pkg::ST_MUL_P:       state_in = pidtm_pkg::ST_MUL_D;
         pidtm_pkg::ST_MUL_D:       state_in = pidtm_pkg::ST_DIV_START;
         pidtm_pkg::ST_DIV_START:   state_in = pidtm_pkg::ST_DIV_WAIT;
         pidtm_pkg::ST_DIV_WAIT:    if (div_done) state_in = pidtm_pkg::ST_SUM;
         pidtm_pkg::ST_SUM:         state_in = pidtm_pkg::ST_OUT;
         pidtm_pkg::ST_I_MUL_P:     state_in = pidtm_pkg::ST_I_MUL_GI;
         pidtm_pkg::ST_I_MUL_GI:    state_in = pidtm_pkg::ST_I_MUL_IDT;
         pidtm_pkg::ST_I_MUL_IDT:   state_in = pidtm_pkg::ST_I_MUL_D;
         pidtm_pkg::ST_I_MUL_D:     state_in = pidtm_pkg::ST_I_DIV_START;
         pidtm_pkg::ST_I_DIV_START: state_in = pidtm_pkg::ST_I_DIV_WAIT;
         pidtm_pkg::ST_I_DIV_WAIT:  if (div_done) state_in = pidtm_pkg::ST_I_SUM;
         pidtm_pkg::ST_I_SUM:       state_in = pidtm_pkg::ST_OUT;
         pidtm_pkg::ST_OUT:         state_in = pidtm_pkg::ST_IDLE;
         default:                   state_in = pidtm_pkg::ST_IDLE;
      endcase
   end

   // datapath; the multiplier result mq follows its operand load through mx_ff/my_ff and prod_ff
   always_comb begin
      t_in = t_ff; m_in = m_ff; dt_in = dt_ff; err_in = err_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; integ_in = integ_ff;
      mx_in = mx_ff; my_in = my_ff;
      isum_in = isum_ff; lerr_in = lerr_ff; lout_in = lout_ff; hist_in = hist_ff;
      rv_in = rv_ff && !rsp_tready; held_in = held_ff; drive_in = drive_ff;
      div_start = 1'b0; div_num = a_ff; s_tmp = '0; clamp_src = lout_ff;
      unique case (state_ff)
         pidtm_pkg::ST_IDLE:
            if (req_fire) begin
               t_in = req_tdata[31:0]; m_in = req_tdata[63:32]; dt_in = req_tdata[95:64];
            end
         pidtm_pkg::ST_ERR: begin
            err_in = pidtm_pkg::sat32(66'(t_ff) - 66'(m_ff));
            mx_in = pidtm_pkg::sat32(66'(t_ff) - 66'(m_ff));
            my_in = kp_ff;
         end
         pidtm_pkg::ST_MUL_SEP: ;
         pidtm_pkg::ST_SEP: begin
            // mq = sat(e*kp), also the P term
            a_in = mq;
            integ_in = ((65'(mq) <<< 1) < 65'(ohi_ff));
            mx_in = err_ff; my_in = dt_ff;
         end
         pidtm_pkg::ST_MUL_EDT: ;
         pidtm_pkg::ST_INTEG: begin
            if (integ_ff) begin
               s_tmp = pidtm_pkg::sat32(66'(isum_ff) + 66'(mq));
               if (66'(s_tmp) < -66'(lim)) s_tmp = -lim;
               else if (s_tmp > lim) s_tmp = lim;
               isum_in = s_tmp;
               mx_in = ki_ff; my_in = s_tmp;
            end else begin
               mx_in = ki_ff; my_in = isum_ff;
            end
         end
         pidtm_pkg::ST_MUL_GI: begin
            mx_in = pidtm_pkg::sat32(-66'(kd_ff));
            my_in = pidtm_pkg::sat32(66'(m_ff) - 66'(hist_ff));
         end
         pidtm_pkg::ST_MUL_P: b_in = mq;   // ki*integral
         pidtm_pkg::ST_MUL_D: c_in = mq;   // -kd*dmeas
         pidtm_pkg::ST_DIV_START: begin
            div_start = 1'b1; div_num = c_ff;
         end
         pidtm_pkg::ST_DIV_WAIT: ;
         pidtm_pkg::ST_SUM: begin
            s_tmp = pidtm_pkg::sat32(66'(a_ff) + 66'(b_ff) + 66'(div_q));
            lout_in = s_tmp; lerr_in = err_ff; hist_in = m_ff;
         end
         pidtm_pkg::ST_I_MUL_P: begin
            mx_in = kp_ff; my_in = pidtm_pkg::sat32(66'(err_ff) - 66'(lerr_ff));
         end
         pidtm_pkg::ST_I_MUL_GI: begin
            mx_in = ki_ff; my_in = err_ff;
         end
         pidtm_pkg::ST_I_MUL_IDT: begin
            a_in = mq;                     // P term
            mx_in = kd_ff;
            my_in = pidtm_pkg::sat32(66'(err_ff) - (66'(lerr_ff) <<< 1) + 66'(hist_ff));
         end
         pidtm_pkg::ST_I_MUL_D: begin
            mx_in = mq; my_in = dt_ff;     // (ki*e)*dt
         end
         pidtm_pkg::ST_I_DIV_START: begin
            c_in = mq; div_start = 1'b1; div_num = mq; // kd*dd
         end
         // (ki*e)*dt product is ready here and held while the divider runs
         pidtm_pkg::ST_I_DIV_WAIT: b_in = mq;
         pidtm_pkg::ST_I_SUM: begin
            s_tmp = pidtm_pkg::sat32(66'(lout_ff) + 66'(a_ff) + 66'(b_ff) + 66'(div_q));
            lout_in = s_tmp; hist_in = lerr_ff; lerr_in = err_ff;
         end
         pidtm_pkg::ST_OUT: begin
            held_in = dt_ff[31] || dt_ff == '0;
            clamp_src = lout_ff;
            if (clamp_src < olo_ff) drive_in = olo_ff;
            else if (clamp_src > ohi_ff) drive_in = ohi_ff;
            else drive_in = clamp_src;
            rv_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in; m_ff <= m_in; dt_ff <= dt_in; err_ff <= err_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; integ_ff <= integ_in;
      mx_ff <= mx_in; my_ff <= my_in; prod_ff <= 64'(mx_ff) * 64'(my_ff);
      drive_ff <= drive_in; held_ff <= held_in;
      if (reset) begin
         state_ff <= pidtm_pkg::ST_IDLE; rv_ff <= 1'b0;
         isum_ff <= '0; lerr_ff <= '0; lout_ff <= '0; hist_ff <= '0;
      end else begin
         state_ff <= state_in; rv_ff <= rv_in;
         isum_ff <= isum_in; lerr_ff <= lerr_in; lout_ff <= lout_in; hist_ff <= hist_in;
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = drive_ff;
   assign rsp_tuser  = held_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != pidtm_pkg::ST_IDLE) |-> !req_tready) else $error("accept while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp_tready) |=> rv_ff) else $error("response dropped");
   a_drive_window: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && olo_ff <= ohi_ff) |-> (drive_ff >= olo_ff && drive_ff <= ohi_ff))
      else $error("drive outside window");
endmodule
`default_nettype wire

/* rtl/pidtm_div.sv */
// Radix-2 restoring divider: (a * 65536) / dt, truncating toward zero, saturated.
`default_nettype none
module pidtm_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic signed [31:0]  numer,
   input  wire logic signed [31:0]  denom,
   output logic                     done,
   output logic signed [31:0]       quot
);
   logic [47:0] rem_ff, rem_in;
   logic [47:0] q_ff, q_in;
   logic [47:0] n_ff, n_in;
   logic [31:0] d_ff, d_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [48:0] trial;
   logic [48:0] shifted;
   logic signed [65:0] sq;

   always_comb begin
      rem_in = rem_ff; q_in = q_ff; n_in = n_ff; d_in = d_ff;
      neg_in = neg_ff; cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      shifted = {rem_ff, n_ff[47]};
      trial = shifted - {17'd0, d_ff};
      if (start) begin
         neg_in = numer[31];
         n_in = {(numer[31] ? 32'(-numer) : 32'(numer)), 16'd0};
         d_in = denom;
         rem_in = '0; q_in = '0; cnt_in = 6'd48; busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in = {n_ff[46:0], 1'b0};
         if (!trial[48]) begin
            rem_in = trial[47:0]; q_in = {q_ff[46:0], 1'b1};
         end else begin
            rem_in = shifted[47:0]; q_in = {q_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; q_ff <= q_in; n_ff <= n_in; d_ff <= d_in; neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   always_comb begin
      sq = neg_ff ? -$signed({18'd0, q_ff}) : $signed({18'd0, q_ff});
      quot = pidtm_pkg::sat32(sq);
   end
   assign done = done_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without busy");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != 6'd0) else $error("divider count underflow");
endmodule
`default_nettype wire

/* test/tb_top.sv */
// Testbench for the two-mode Q16.16 PID unit: scoreboard with its own predictor, random traffic.
`timescale 1ns / 1ps
`default_nettype none

// Tracks the controller state and holds the expected drive words in order.
class pid_scoreboard;
   bit                mode;
   logic signed [31:0] kp, ki, kd, lo, hi;
   logic [30:0]       cap;
   logic signed [31:0] isum, e1, yprev, hist;
   logic [32:0]       pending[$];   // {held, drive}
   int                errors;
   int                shown;

   function new();
      mode = 0; kp = 0; ki = 0; kd = 0;
      lo = -32'sd6553600; hi = 32'sd6553600; cap = 0;
      isum = 0; e1 = 0; yprev = 0; hist = 0;
      errors = 0; shown = 0;
   endfunction

   function logic signed [31:0] clip(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // floor of the product shifted by 16, then saturated
   function logic signed [31:0] fmul(input logic signed [31:0] a, input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return clip(66'(p >>> 16));
   endfunction

   function logic signed [31:0] fdiv(input logic signed [31:0] a, input logic signed [31:0] dt);
      logic signed [63:0] n;
      n = 64'(a) * 64'sd65536;
      return clip(66'(n / 64'(dt)));
   endfunction

   function logic signed [31:0] window(input logic signed [31:0] v);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function void write_reg(input logic [2:0] idx, input logic [31:0] d);
      case (idx)
         pidtm_pkg::CsrMode:    mode = d[0];
         pidtm_pkg::CsrGainP:   kp = d;
         pidtm_pkg::CsrGainI:   ki = d;
         pidtm_pkg::CsrGainD:   kd = d;
         pidtm_pkg::CsrOutLow:  lo = d;
         pidtm_pkg::CsrOutHigh: hi = d;
         pidtm_pkg::CsrIntCap:  cap = d[30:0];
         default: ;
      endcase
   endfunction

   function void note_request(input logic signed [31:0] t, input logic signed [31:0] m,
                              input logic signed [31:0] dt);
      logic signed [31:0] e, dm, sep, lim, s, der, y, pt, it, dd, dterm;
      logic signed [33:0] span;
      if (dt <= 0) begin
         pending.push_back({1'b1, window(yprev)});
         return;
      end
      e = clip(66'(t) - 66'(m));
      if (!mode) begin
         dm = clip(66'(m) - 66'(hist));
         sep = fmul(e, kp);
         if (66'(sep) * 2 < 66'(hi)) begin
            if (cap != 0) lim = {1'b0, cap};
            else begin
               span = 34'(hi) - 34'(lo);
               lim = (span < 0) ? 32'sd0 : 32'(span / 2);
            end
            s = clip(66'(isum) + 66'(fmul(e, dt)));
            if (s < -lim) s = -lim;
            else if (s > lim) s = lim;
            isum = s;
         end
         der = fdiv(fmul(clip(-66'(kd)), dm), dt);
         y = clip(66'(fmul(kp, e)) + 66'(fmul(ki, isum)) + 66'(der));
         hist = m;
      end else begin
         pt = fmul(kp, clip(66'(e) - 66'(e1)));
         it = fmul(fmul(ki, e), dt);
         dd = clip(66'(e) - 2 * 66'(e1) + 66'(hist));
         dterm = fdiv(fmul(kd, dd), dt);
         y = clip(66'(yprev) + 66'(pt) + 66'(it) + 66'(dterm));
         hist = e1;
      end
      e1 = e;
      yprev = y;
      pending.push_back({1'b0, window(y)});
   endfunction

   function void check_response(input logic [31:0] drive, input logic held);
      logic [32:0] want;
      if (pending.size() == 0) begin
         errors++;
         if (shown < 10) begin
            shown++;
            $display("unexpected word: drive %h held %b", drive, held);
         end
         return;
      end
      want = pending.pop_front();
      if (want !== {held, drive}) begin
         errors++;
         if (shown < 10) begin
            shown++;
            $display("mismatch: expected drive %h held %b, got drive %h held %b",
                     want[31:0], want[32], drive, held);
         end
      end
   endfunction
endclass

module tb_top;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   pid_scoreboard sb = new();

   int  send_idle = 0;      // percent of cycles the sender sits out
   int  recv_idle = 0;      // percent of cycles the receiver stalls
   int  hold_off = 0;       // long receiver stall, in cycles
   longint cycles = 0;

   pid_controller_two_mode_unit i_dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 64'd2500000) begin
         $display("** pid_controller_two_mode_unit: FAILED **");
         $finish;
      end
   end

   // receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tuser);
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else
         rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   // write enable drops for one cycle between writes
   task automatic write_csr(input logic [2:0] idx, input logic [31:0] d);
      csr_we <= 1; csr_index <= idx; csr_wdata <= d;
      @(posedge clock);
      csr_we <= 0;
      sb.write_reg(idx, d);
      @(posedge clock);
   endtask

   // word stays valid until taken; model updated at acceptance; valid is left
   // high for the next word and dropped by idling, drain or a pause
   task automatic send_word(input logic [31:0] t, input logic [31:0] m, input logic [31:0] dt);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {dt, m, t};
      do @(posedge clock); while (!req_tready);
      sb.note_request(t, m, dt);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(32'h000c_0000) - 32'h0006_0000;
         3: return $urandom_range(32'h0002_0000) - 32'h0001_0000;
         default: return $urandom;
      endcase
   endfunction

   // step sizes: mostly small positive, some held steps and extremes
   function automatic logic [31:0] pick_step();
      case ($urandom_range(9))
         0: return 0;
         1: return $urandom | 32'h80000000;
         2: return $urandom;
         3: return 1;
         default: return $urandom_range(32'h0002_0000, 1);
      endcase
   endfunction

   task automatic load_settings(input int phase);
      logic signed [31:0] a, b;
      write_csr(pidtm_pkg::CsrMode, {31'd0, phase[0]});
      write_csr(pidtm_pkg::CsrGainP,
                (phase % 3 == 0) ? pick_value() : $urandom_range(32'h40000));
      write_csr(pidtm_pkg::CsrGainI,
                (phase % 3 == 1) ? pick_value() : $urandom_range(32'h20000));
      write_csr(pidtm_pkg::CsrGainD,
                (phase % 3 == 2) ? pick_value() : $urandom_range(32'h10000));
      a = $urandom_range(32'h0100_0000); b = $urandom_range(32'h0100_0000);
      case (phase % 4)
         0: begin
            write_csr(pidtm_pkg::CsrOutLow, 32'h80000000);
            write_csr(pidtm_pkg::CsrOutHigh, 32'h7fffffff);
         end
         1: begin  // inverted
            write_csr(pidtm_pkg::CsrOutLow, a);
            write_csr(pidtm_pkg::CsrOutHigh, -b);
         end
         default: begin
            write_csr(pidtm_pkg::CsrOutLow, -a);
            write_csr(pidtm_pkg::CsrOutHigh, b);
         end
      endcase
      case (phase % 3)
         0: write_csr(pidtm_pkg::CsrIntCap, 0);
         1: write_csr(pidtm_pkg::CsrIntCap, 32'h7fffffff);
         default: write_csr(pidtm_pkg::CsrIntCap, $urandom_range(32'h0080_0000));
      endcase
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, both modes, held steps, full-range gains
      write_csr(pidtm_pkg::CsrGainP, 32'h0001_0000);
      write_csr(pidtm_pkg::CsrGainI, 32'h0000_8000);
      write_csr(pidtm_pkg::CsrGainD, 32'h0000_4000);
      send_word(32'h0001_0000, 0, 0);
      send_word(32'h0001_0000, 0, 32'h0000_1000);
      send_word(32'h0001_0000, 0, 32'h8000_0000);
      send_word(32'h7fffffff, 32'h80000000, 1);
      send_word(32'h80000000, 32'h7fffffff, 32'h7fffffff);
      send_word(0, 32'h0040_0000, 32'h0000_0100);
      send_word(32'h0000_2000, 32'h0000_1000, 32'hffffffff);
      drain();
      write_csr(pidtm_pkg::CsrMode, 1);
      write_csr(pidtm_pkg::CsrGainP, 32'h7fffffff);
      write_csr(pidtm_pkg::CsrGainI, 32'h80000000);
      write_csr(pidtm_pkg::CsrGainD, 32'h7fffffff);
      write_csr(pidtm_pkg::CsrIntCap, 32'h0001_0000);
      send_word(32'h0005_0000, 0, 32'h0001_0000);
      send_word(32'h80000000, 32'h7fffffff, 1);
      send_word(32'h7fffffff, 32'h80000000, 32'h7fffffff);
      send_word(0, 0, 0);
      drain();
      write_csr(pidtm_pkg::CsrMode, 0);
      write_csr(pidtm_pkg::CsrOutLow, 32'h0010_0000);    // inverted window
      write_csr(pidtm_pkg::CsrOutHigh, 32'hfff0_0000);
      write_csr(pidtm_pkg::CsrIntCap, 0);
      send_word(32'h0003_0000, 32'h0001_0000, 32'h0001_0000);
      send_word(32'h0003_0000, 32'h0001_0000, 0);
      drain();

      // random phases with varied idling
      for (int ph = 0; ph < 16; ph++) begin
         load_settings(ph);
         case (ph % 4)
            0: begin send_idle = 0;  recv_idle = 0;  end
            1: begin send_idle = 63; recv_idle = 0;  end
            2: begin send_idle = 0;  recv_idle = 63; end
            default: begin send_idle = 27; recv_idle = 27; end
         endcase
         if (ph == 5) hold_off = 400;   // block backs up while sender keeps offering
         for (int n = 0; n < 100; n++) begin
            send_word(pick_value(), pick_value(), pick_step());
            if (ph == 6 && n == 50) begin   // sender waits for all results
               req_tvalid <= 0;
               while (sb.pending.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("** pid_controller_two_mode_unit: PASSED **");
      else
         $display("** pid_controller_two_mode_unit: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
